/* design/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and types of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // slot addressing: the table holds 1 << SLOT_W slots
  localparam int SLOT_W    = 10;
  localparam int SLOTS     = 1 << SLOT_W;
  localparam int LOG2_W    = 4;
  localparam int KEY_W     = 32;
  localparam int INDEX_W   = 32;
  localparam int PAYLOAD_W = 64;

  // size register reset value
  localparam logic [LOG2_W-1:0] SIZE_LOG2_RST = LOG2_W'(SLOT_W);

  // key reserved as the empty marker
  localparam logic [KEY_W-1:0] KEY_EMPTY = '1;

  // fmix32 multipliers
  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RESERVED  = 2'd3
  } status_e;

  // one slot word in the store
  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [INDEX_W-1:0]   index;
    logic [PAYLOAD_W-1:0] payload;
  } slot_entry_t;

  // store access command: write when we is set, otherwise read
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       wdata;
  } store_cmd_t;

endpackage

/* design/lpht_req_if.sv */
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  import lpht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [KEY_W-1:0]     key;
  logic [INDEX_W-1:0]   entry_index;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, req_type, key, entry_index, payload, input ready);
  modport sink   (input valid, req_type, key, entry_index, payload, output ready);
endinterface

/* design/lpht_rsp_if.sv */
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [SLOT_W-1:0]    slot;
  logic [INDEX_W-1:0]   found_index;
  logic [PAYLOAD_W-1:0] found_payload;

  modport source (output valid, status, slot, found_index, found_payload, input ready);
  modport sink   (input valid, status, slot, found_index, found_payload, output ready);
endinterface

/* design/lpht_mix.sv */
// ----------------------------------------------------------------------------
// lpht_mix
// Two-stage murmur3 fmix32 pipeline, one multiply per stage.
// ----------------------------------------------------------------------------
module lpht_mix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lpht_pkg::KEY_W-1:0] key_i,
  output logic                      valid_o,
  output logic [31:0]               hash_o
);
  import lpht_pkg::*;

  logic        va_q, vb_q;
  logic [31:0] a_q, b_q;
  logic [31:0] k1, k2;

  // first xor-shift and multiply
  assign k1 = key_i ^ (key_i >> 16);
  // second xor-shift feeding the second multiply
  assign k2 = a_q ^ (a_q >> 13);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= start_i;
      vb_q <= va_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    a_q <= 32'(k1 * MIX_C1);
    b_q <= 32'(k2 * MIX_C2);
  end

  // final xor-shift
  assign hash_o  = b_q ^ (b_q >> 16);
  assign valid_o = vb_q;

  // a hash comes out once its start has passed the va_q and vb_q stage registers
  a_mix_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 2))
    else $error("hash valid without a start two cycles earlier");

  a_mix_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 valid_o)
    else $error("started hash did not come out");

  a_mix_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |=> vb_q)
    else $error("pipeline stage lost its valid");

endmodule

/* design/lpht_store.sv */
// ----------------------------------------------------------------------------
// lpht_store
// Slot memory: one word per slot (valid, key, index, payload), single port,
// registered read data.
// ----------------------------------------------------------------------------
module lpht_store (
  input  logic                   clk_i,
  input  lpht_pkg::store_cmd_t   cmd_i,
  output lpht_pkg::slot_entry_t  rdata_o
);
  import lpht_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rdata_q;

  // write, or registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.addr] <= cmd_i.wdata;
    end else begin
      rdata_q <= mem[cmd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/linear_probe_hash_table_top.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table of 32-bit keys with linear probing.
// ----------------------------------------------------------------------------
// channel   direction  handshake          fields
// req       in         req.valid/ready    req_type, key, entry_index, payload
// rsp       out        rsp.valid/ready    status, slot, found_index, found_payload
// cfg       in         cfg_we_i           cfg_data_i (size_log2)
//
// insert/lookup: accept, hash wait in S_HASH, one probe per cycle in S_CHECK, then
//   the result via S_DONE; the probe rate is bound by the single slot memory port
// clear: a sweep over all 1024 slots of the slot memory, then the result
// after reset the same sweep runs before req.ready rises
// one transaction in flight; a new request is taken while the last result
//   still waits in the output register
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lpht_req_if.sink                     req,
  lpht_rsp_if.source                   rsp,
  input  logic                         cfg_we_i,
  input  logic [lpht_pkg::LOG2_W-1:0]  cfg_data_i
);
  import lpht_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_CHECK = 6'b001000,
    S_DONE  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [LOG2_W-1:0]    size_log2_q;
  logic [LOG2_W-1:0]    eff_log2;
  logic [SLOT_W-1:0]    mask;

  logic [1:0]           op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [INDEX_W-1:0]   idx_q, idx_d;
  logic [PAYLOAD_W-1:0] pay_q, pay_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [SLOT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]    clr_q, clr_d;
  logic                 clr_reply_q, clr_reply_d;

  status_e              res_status_q, res_status_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic [INDEX_W-1:0]   res_idx_q, res_idx_d;
  logic [PAYLOAD_W-1:0] res_pay_q, res_pay_d;

  logic                 rsp_valid_q, rsp_valid_d;
  logic                 rsp_load;
  status_e              rsp_status_q;
  logic [SLOT_W-1:0]    rsp_slot_q;
  logic [INDEX_W-1:0]   rsp_idx_q;
  logic [PAYLOAD_W-1:0] rsp_pay_q;

  logic                 mix_start;
  logic                 mix_valid;
  logic [31:0]          mix_hash;

  store_cmd_t           store_cmd;
  slot_entry_t          rd;
  logic                 used, hit, last;
  logic [SLOT_W-1:0]    next_slot;
  logic                 accept;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_LOG2_RST;
    end else if (cfg_we_i) begin
      size_log2_q <= cfg_data_i;
    end
  end

  // table size saturates at the memory depth
  assign eff_log2 = (size_log2_q > LOG2_W'(SLOT_W)) ? LOG2_W'(SLOT_W) : size_log2_q;
  assign mask     = ~({SLOT_W{1'b1}} << eff_log2);

  // hash unit and slot memory
  lpht_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .key_i   (req.key),
    .valid_o (mix_valid),
    .hash_o  (mix_hash)
  );

  lpht_store u_store (
    .clk_i   (clk_i),
    .cmd_i   (store_cmd),
    .rdata_o (rd)
  );

  // probe evaluation
  assign accept    = req.valid && req.ready;
  assign used      = rd.valid;
  assign hit       = used && (rd.key == key_q);
  assign last      = (cnt_q == mask);
  assign next_slot = (slot_q + SLOT_W'(1)) & mask;
  assign req.ready = (state_q == S_IDLE);
  assign rsp_load  = (state_q == S_DONE || state_q == S_HOLD) && (!rsp_valid_q || rsp.ready);

  // control sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    idx_d        = idx_q;
    pay_d        = pay_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    clr_reply_d  = clr_reply_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_idx_d    = res_idx_q;
    res_pay_d    = res_pay_q;
    mix_start    = 1'b0;
    store_cmd    = '{we: 1'b0, addr: slot_q, wdata: '{valid: 1'b1, key: key_q,
                     index: idx_q, payload: pay_q}};

    case (state_q)
      S_CLEAR: begin
        store_cmd.we          = 1'b1;
        store_cmd.addr        = clr_q;
        store_cmd.wdata.valid = 1'b0;
        clr_d                 = clr_q + SLOT_W'(1);
        if (clr_q == {SLOT_W{1'b1}}) begin
          state_d = clr_reply_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d         = req.req_type;
          key_d        = req.key;
          idx_d        = req.entry_index;
          pay_d        = req.payload;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_idx_d    = '0;
          res_pay_d    = '0;
          case (req.req_type)
            REQ_CLEAR: begin
              clr_d       = '0;
              clr_reply_d = 1'b1;
              state_d     = S_CLEAR;
            end
            REQ_INSERT, REQ_LOOKUP: begin
              if (req.key == KEY_EMPTY) begin
                res_status_d = ST_RESERVED;
                state_d      = S_DONE;
              end else begin
                mix_start = 1'b1;
                state_d   = S_HASH;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (mix_valid) begin
          slot_d         = mix_hash[SLOT_W-1:0] & mask;
          cnt_d          = '0;
          store_cmd.addr = mix_hash[SLOT_W-1:0] & mask;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_q == REQ_INSERT) begin
          if (!used || hit) begin
            store_cmd.we = 1'b1;
            res_slot_d   = slot_q;
            state_d      = S_DONE;
          end else if (last) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            store_cmd.addr = next_slot;
            slot_d         = next_slot;
            cnt_d          = cnt_q + SLOT_W'(1);
          end
        end else begin
          if (hit) begin
            res_slot_d = slot_q;
            res_idx_d  = rd.index;
            res_pay_d  = rd.payload;
            state_d    = S_DONE;
          end else if (!used || last) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            store_cmd.addr = next_slot;
            slot_d         = next_slot;
            cnt_d          = cnt_q + SLOT_W'(1);
          end
        end
      end
      S_DONE: begin
        state_d = rsp_load ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_reply_q <= clr_reply_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pay_q        <= pay_d;
    slot_q       <= slot_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_idx_q    <= res_idx_d;
    res_pay_q    <= res_pay_d;
  end

  // output register
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_slot_q   <= res_slot_q;
      rsp_idx_q    <= res_idx_q;
      rsp_pay_q    <= res_pay_q;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = rsp_status_q;
  assign rsp.slot          = rsp_slot_q;
  assign rsp.found_index   = rsp_idx_q;
  assign rsp.found_payload = rsp_pay_q;

  // memory writes only during the sweep or a successful insert probe
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_cmd.we |-> (state_q == S_CLEAR || state_q == S_CHECK))
    else $error("slot memory written outside sweep or probe");

  // probing never runs past the table in use
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ((cnt_q & ~mask) == '0))
    else $error("probe count beyond table size");

  // a hash only arrives while the sequencer waits for it
  a_hash_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_valid |-> (state_q == S_HASH))
    else $error("hash arrived outside the hash wait");

  // a finished result is never dropped while the output holds one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp.ready) |-> !rsp_load)
    else $error("result loaded over a pending response");

endmodule
